### hw/rtl/htd_pkg.sv
// shared types, codes and helpers for the huffman table decoder
package htd_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int MAX_CODE_LEN = 31;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = IDX_W + 1;
    localparam int LEN_W        = 5;
    localparam int SYM_W        = 8;
    localparam int COUNT_W      = 32;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;
    localparam logic [1:0] KIND_DRAIN = 2'd3;

    localparam logic [1:0] ST_SYMBOL = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_ACK    = 2'd2;

    typedef enum logic [1:0] {
        PH_LOAD   = 2'd0,
        PH_DECODE = 2'd1,
        PH_DONE   = 2'd2,
        PH_ERROR  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [SYM_W-1:0]        sym;
        logic [LEN_W-1:0]        len;
        logic [MAX_CODE_LEN-1:0] code;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } tbl_wr_t;

    // ones in the low n bits of a code word
    function automatic logic [MAX_CODE_LEN-1:0] low_mask(input logic [LEN_W-1:0] n);
        low_mask = (MAX_CODE_LEN'(1) << n) - MAX_CODE_LEN'(1);
    endfunction

endpackage

### hw/rtl/htd_table.sv
// code table memory, one write port, one registered read port
module htd_table (
    input  logic                       clk,
    input  htd_pkg::tbl_wr_t           wr,
    input  logic [htd_pkg::IDX_W-1:0]  rd_addr,
    output htd_pkg::entry_t            rd_data
);

    htd_pkg::entry_t mem [htd_pkg::TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hw/rtl/huffman_table_decoder.sv
// huffman decoder top level: item handling, bit shifting and table scan
//
// items are taken with start while busy is low. load, start and drain
// items give one result the next cycle. a data byte runs bit by bit:
// each bit shifts into the code accumulator and then the table is
// scanned entry by entry through its one read port, each entry first
// addressed, then compared, and a closing step ends the item; a scan
// stops at the first hit. results appear one per cycle on strobe and
// must be taken when shown, the block never waits for the receiver. the
// last result of an item carries last, and a byte that yields no symbol
// and no error gives one acknowledge. the table memory needs no clearing:
// only loaded entries can ever match.
module huffman_table_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          kind,
    input  logic [htd_pkg::SYM_W-1:0]           entry_symbol,
    input  logic [htd_pkg::LEN_W-1:0]           entry_length,
    input  logic [htd_pkg::MAX_CODE_LEN-1:0]    entry_code,
    input  logic [htd_pkg::COUNT_W-1:0]         symbol_count,
    input  logic [7:0]                          data_byte,
    output logic                                strobe,
    output logic [htd_pkg::SYM_W-1:0]           symbol,
    output logic [1:0]                          status,
    output logic                                all_done,
    output logic                                last
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_BIT   = 5'b00010,
        S_READ  = 5'b00100,
        S_CMP   = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    htd_pkg::phase_t phase_reg, phase_next;
    logic [htd_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [htd_pkg::LEN_W-1:0]        longest_reg, longest_next;
    logic [htd_pkg::COUNT_W-1:0]      left_reg, left_next;
    logic [htd_pkg::MAX_CODE_LEN-1:0] acc_reg, acc_next;
    logic [htd_pkg::LEN_W-1:0]        gath_reg, gath_next;
    logic                             zero_valid_reg, zero_valid_next;
    logic [htd_pkg::SYM_W-1:0]        zero_sym_reg, zero_sym_next;
    logic [7:0]                       byte_reg, byte_next;
    logic [2:0]                       bit_reg, bit_next;
    logic [htd_pkg::IDX_W-1:0]        scan_reg, scan_next;

    // held result: lets the last flag land on the true final result
    logic                      pend_valid_reg, pend_valid_next;
    logic [htd_pkg::SYM_W-1:0] pend_sym_reg, pend_sym_next;
    logic [1:0]                pend_status_reg, pend_status_next;
    logic                      pend_done_reg, pend_done_next;

    logic                      strobe_reg, strobe_next;
    logic [htd_pkg::SYM_W-1:0] symbol_reg, symbol_next;
    logic [1:0]                status_reg, status_next;
    logic                      all_done_reg, all_done_next;
    logic                      last_reg, last_next;

    htd_pkg::tbl_wr_t wr;
    htd_pkg::entry_t  rd_data;

    logic [htd_pkg::LEN_W-1:0]   len_sat;
    logic [htd_pkg::COUNT_W-1:0] left_dec;
    logic                        hit;
    logic                        scan_end;
    logic                        new_res;
    logic [htd_pkg::SYM_W-1:0]   new_sym;
    logic [1:0]                  new_status;
    logic                        new_done;

    htd_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (scan_reg),
        .rd_data (rd_data)
    );

    assign len_sat  = (entry_length > htd_pkg::LEN_W'(htd_pkg::MAX_CODE_LEN))
                    ? htd_pkg::LEN_W'(htd_pkg::MAX_CODE_LEN) : entry_length;
    assign left_dec = left_reg - htd_pkg::COUNT_W'(1);
    assign hit      = (count_reg != '0) && (rd_data.len == gath_reg) && (rd_data.code == acc_reg);
    assign scan_end = (htd_pkg::CNT_W'(scan_reg) + htd_pkg::CNT_W'(1)) >= count_reg;
    assign busy     = (state_reg != S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        count_next       = count_reg;
        longest_next     = longest_reg;
        left_next        = left_reg;
        acc_next         = acc_reg;
        gath_next        = gath_reg;
        zero_valid_next  = zero_valid_reg;
        zero_sym_next    = zero_sym_reg;
        byte_next        = byte_reg;
        bit_next         = bit_reg;
        scan_next        = scan_reg;
        pend_valid_next  = pend_valid_reg;
        pend_sym_next    = pend_sym_reg;
        pend_status_next = pend_status_reg;
        pend_done_next   = pend_done_reg;
        strobe_next      = 1'b0;
        symbol_next      = symbol_reg;
        status_next      = status_reg;
        all_done_next    = all_done_reg;
        last_next        = 1'b0;
        wr.en            = 1'b0;
        wr.addr          = count_reg[htd_pkg::IDX_W-1:0];
        wr.data.sym      = entry_symbol;
        wr.data.len      = len_sat;
        wr.data.code     = entry_code & htd_pkg::low_mask(len_sat);
        new_res          = 1'b0;
        new_sym          = '0;
        new_status       = htd_pkg::ST_SYMBOL;
        new_done         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // single result items report straight away
                    strobe_next   = 1'b1;
                    last_next     = 1'b1;
                    symbol_next   = '0;
                    status_next   = htd_pkg::ST_ACK;
                    all_done_next = 1'b0;
                    case (kind)
                        htd_pkg::KIND_LOAD:
                        begin
                            if (phase_reg != htd_pkg::PH_LOAD)
                            begin
                                // new table: forget the old one
                                count_next      = '0;
                                longest_next    = '0;
                                left_next       = '0;
                                acc_next        = '0;
                                gath_next       = '0;
                                zero_valid_next = 1'b0;
                                phase_next      = htd_pkg::PH_LOAD;
                                wr.addr         = '0;
                            end
                            if (phase_reg != htd_pkg::PH_LOAD
                                || count_reg < htd_pkg::CNT_W'(htd_pkg::TABLE_DEPTH))
                            begin
                                wr.en = 1'b1;
                                count_next = ((phase_reg != htd_pkg::PH_LOAD) ? '0 : count_reg)
                                           + htd_pkg::CNT_W'(1);
                                if (len_sat > ((phase_reg != htd_pkg::PH_LOAD) ? '0 : longest_reg))
                                begin
                                    longest_next = len_sat;
                                end
                                // first zero-length entry decodes without bits
                                if (len_sat == '0
                                    && !(zero_valid_reg && phase_reg == htd_pkg::PH_LOAD))
                                begin
                                    zero_valid_next = 1'b1;
                                    zero_sym_next   = entry_symbol;
                                end
                            end
                        end
                        htd_pkg::KIND_START:
                        begin
                            left_next  = symbol_count;
                            acc_next   = '0;
                            gath_next  = '0;
                            phase_next = (symbol_count != '0) ? htd_pkg::PH_DECODE
                                                             : htd_pkg::PH_DONE;
                        end
                        htd_pkg::KIND_DATA:
                        begin
                            if (phase_reg == htd_pkg::PH_DECODE && !zero_valid_reg)
                            begin
                                strobe_next = 1'b0;
                                last_next   = 1'b0;
                                byte_next   = data_byte;
                                bit_next    = 3'd7;
                                state_next  = S_BIT;
                            end
                        end
                        default:
                        begin
                            // drain: one bitless symbol from a zero-length entry
                            if (phase_reg == htd_pkg::PH_DECODE && gath_reg == '0
                                && zero_valid_reg)
                            begin
                                left_next     = left_dec;
                                acc_next      = '0;
                                symbol_next   = zero_sym_reg;
                                status_next   = htd_pkg::ST_SYMBOL;
                                all_done_next = (left_dec == '0);
                                if (left_dec == '0)
                                begin
                                    phase_next = htd_pkg::PH_DONE;
                                end
                            end
                        end
                    endcase
                end
            end
            S_BIT:
            begin
                acc_next   = {acc_reg[htd_pkg::MAX_CODE_LEN-2:0], byte_reg[bit_reg]};
                gath_next  = gath_reg + htd_pkg::LEN_W'(1);
                scan_next  = '0;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (hit)
                begin
                    new_res    = 1'b1;
                    new_sym    = rd_data.sym;
                    new_status = htd_pkg::ST_SYMBOL;
                    new_done   = (left_dec == '0);
                    left_next  = left_dec;
                    acc_next   = '0;
                    gath_next  = '0;
                    if (left_dec == '0)
                    begin
                        // count reached: rest of the byte is padding
                        phase_next = htd_pkg::PH_DONE;
                        state_next = S_FLUSH;
                    end
                    else if (bit_reg == '0)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        bit_next   = bit_reg - 3'd1;
                        state_next = S_BIT;
                    end
                end
                else if (!scan_end)
                begin
                    scan_next  = scan_reg + htd_pkg::IDX_W'(1);
                    state_next = S_READ;
                end
                else if (gath_reg >= longest_reg)
                begin
                    new_res    = 1'b1;
                    new_status = htd_pkg::ST_NOMATCH;
                    phase_next = htd_pkg::PH_ERROR;
                    acc_next   = '0;
                    gath_next  = '0;
                    state_next = S_FLUSH;
                end
                else if (bit_reg == '0)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    bit_next   = bit_reg - 3'd1;
                    state_next = S_BIT;
                end
            end
            S_FLUSH:
            begin
                strobe_next     = 1'b1;
                last_next       = 1'b1;
                symbol_next     = pend_valid_reg ? pend_sym_reg : '0;
                status_next     = pend_valid_reg ? pend_status_reg : htd_pkg::ST_ACK;
                all_done_next   = pend_valid_reg && pend_done_reg;
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a fresh result pushes the held one out
        if (new_res)
        begin
            if (pend_valid_reg)
            begin
                strobe_next   = 1'b1;
                symbol_next   = pend_sym_reg;
                status_next   = pend_status_reg;
                all_done_next = pend_done_reg;
            end
            pend_valid_next  = 1'b1;
            pend_sym_next    = new_sym;
            pend_status_next = new_status;
            pend_done_next   = new_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= htd_pkg::PH_LOAD;
            count_reg      <= '0;
            longest_reg    <= '0;
            left_reg       <= '0;
            acc_reg        <= '0;
            gath_reg       <= '0;
            zero_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            longest_reg    <= longest_next;
            left_reg       <= left_next;
            acc_reg        <= acc_next;
            gath_reg       <= gath_next;
            zero_valid_reg <= zero_valid_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_sym_reg    <= zero_sym_next;
        byte_reg        <= byte_next;
        bit_reg         <= bit_next;
        scan_reg        <= scan_next;
        pend_sym_reg    <= pend_sym_next;
        pend_status_reg <= pend_status_next;
        pend_done_reg   <= pend_done_next;
        symbol_reg      <= symbol_next;
        status_reg      <= status_next;
        all_done_reg    <= all_done_next;
    end

    assign strobe   = strobe_reg;
    assign symbol   = symbol_reg;
    assign status   = status_reg;
    assign all_done = all_done_reg;
    assign last     = last_reg;

`ifndef ASSERT_OFF
    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> $past(state_reg) == S_READ)
        else $error("compare without a table read");
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && all_done |-> phase_reg == htd_pkg::PH_DONE)
        else $error("count completed but phase not done");
    a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FLUSH |=> strobe && last && !pend_valid_reg)
        else $error("item closed without a final result");
`endif

endmodule
